// ===== hw/rtl/rsrc_pkg.sv =====
// shared types and constants of the roller shutter relay controller
package rsrc_pkg;

  localparam int unsigned RunTimeW  = 16;
  localparam int unsigned LeadTimeW = 10;
  localparam int unsigned ElapsedW  = 16;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIndexW = 2;

  localparam logic [RunTimeW-1:0]  RunTimeReset  = RunTimeW'(20 * 1000);
  localparam logic [LeadTimeW-1:0] LeadTimeReset = LeadTimeW'(100);
  localparam logic [ElapsedW-1:0]  ElapsedMax    = '1;

  // configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_RUN_TIME_FIRST  = 2'd0,
    CFG_RUN_TIME_SECOND = 2'd1,
    CFG_LEAD_TIME       = 2'd2
  } rsrc_cfg_index_t;

  typedef enum logic [1:0] {
    PHASE_IDLE    = 2'd0,
    PHASE_CLOSING = 2'd1,
    PHASE_LEAD    = 2'd2,
    PHASE_OPENING = 2'd3
  } rsrc_phase_t;

  typedef struct packed {
    logic [RunTimeW-1:0]  run_time_first;
    logic [RunTimeW-1:0]  run_time_second;
    logic [LeadTimeW-1:0] lead_time;
  } rsrc_cfg_t;

  typedef struct packed {
    logic                last_close;
    logic                last_open;
    logic [1:0]          closing;
    logic [1:0]          opening;
    logic                lead_wait;
    logic [ElapsedW-1:0] elapsed;
  } rsrc_state_t;

  typedef struct packed {
    logic        close_button;
    logic        open_button;
    logic        tick;
  } rsrc_sample_t;

  typedef struct packed {
    logic        run_relay_first;
    logic        dir_relay_first;
    logic        run_relay_second;
    logic        dir_relay_second;
    rsrc_phase_t motion_phase;
  } rsrc_result_t;

endpackage

// ===== hw/rtl/rsrc_step.sv =====
// next-state and relay logic for one button sample
module rsrc_step (
  input  rsrc_pkg::rsrc_cfg_t    cfg,
  input  rsrc_pkg::rsrc_state_t  state,
  input  rsrc_pkg::rsrc_sample_t sample,
  output rsrc_pkg::rsrc_state_t  state_next,
  output rsrc_pkg::rsrc_result_t result
);
  import rsrc_pkg::*;

  always_comb begin
    logic close_edge;
    logic open_edge;
    logic pressed;
    logic [1:0] active;
    logic [1:0] keep;
    state_next = state;
    close_edge = sample.close_button & ~state.last_close;
    open_edge  = sample.open_button & ~state.last_open;
    pressed    = close_edge | open_edge;

    // saturating tick count, ahead of every compare
    if (sample.tick && state.elapsed != ElapsedMax) begin
      state_next.elapsed = state.elapsed + ElapsedW'(1);
    end

    // per-shutter auto stop mask
    keep[0] = state_next.elapsed < cfg.run_time_first;
    keep[1] = state_next.elapsed < cfg.run_time_second;

    if (!state.lead_wait) begin
      state_next.last_close = sample.close_button;
      state_next.last_open  = sample.open_button;
      if (state.closing != 2'b00) begin
        state_next.closing = pressed ? 2'b00 : (state.closing & keep);
      end else if (state.opening != 2'b00) begin
        state_next.opening = pressed ? 2'b00 : (state.opening & keep);
      end else if (open_edge) begin
        state_next.lead_wait = 1'b1;
        state_next.elapsed   = '0;
      end else if (close_edge) begin
        state_next.closing = 2'b11;
        state_next.elapsed = '0;
      end
    end

    // lead wait may end in the press sample itself
    if (state_next.lead_wait &&
        state_next.elapsed >= ElapsedW'(cfg.lead_time)) begin
      state_next.lead_wait = 1'b0;
      state_next.opening   = 2'b11;
      state_next.elapsed   = '0;
    end

    active = state_next.closing | state_next.opening;
    result.run_relay_first  = active[0];
    result.run_relay_second = active[1];
    result.dir_relay_first  = state_next.lead_wait | state_next.opening[0];
    result.dir_relay_second = state_next.lead_wait | state_next.opening[1];
    if (state_next.lead_wait) begin
      result.motion_phase = PHASE_LEAD;
    end else if (state_next.closing != 2'b00) begin
      result.motion_phase = PHASE_CLOSING;
    end else if (state_next.opening != 2'b00) begin
      result.motion_phase = PHASE_OPENING;
    end else begin
      result.motion_phase = PHASE_IDLE;
    end
  end

endmodule

// ===== hw/rtl/roller_shutter_relay_controller.sv =====
// top level of the two-shutter roller relay controller
// an accepted word passes through the sample register and then the result register
// throughput: one word per cycle while out_stall allows; the sample register advances
//   whenever the result register is empty or being taken
// reset: synchronous, clears the shutter state and both word valid flags, and restores
//   the configuration defaults (run times 20000 ticks, lead time 100 ticks)
module roller_shutter_relay_controller (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [rsrc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [rsrc_pkg::CfgDataW-1:0]  cfg_data,
  // sample channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         close_button,
  input  logic                         open_button,
  input  logic                         tick,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         run_relay_first,
  output logic                         dir_relay_first,
  output logic                         run_relay_second,
  output logic                         dir_relay_second,
  output logic [1:0]                   motion_phase
);
  import rsrc_pkg::*;

  rsrc_cfg_t    cfg;
  rsrc_state_t  state;
  rsrc_state_t  state_next;
  rsrc_sample_t sample;
  logic         sample_valid;
  rsrc_result_t result_next;
  rsrc_result_t result;
  logic         in_take;
  logic         advance;

  // the sample register moves on when the result register has room
  assign advance  = sample_valid & (~out_valid | ~out_stall);
  assign in_stall = sample_valid & ~advance;
  assign in_take  = in_valid & ~in_stall;

  // configuration registers, unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.run_time_first  <= RunTimeReset;
      cfg.run_time_second <= RunTimeReset;
      cfg.lead_time       <= LeadTimeReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RUN_TIME_FIRST:  cfg.run_time_first  <= cfg_data[RunTimeW-1:0];
        CFG_RUN_TIME_SECOND: cfg.run_time_second <= cfg_data[RunTimeW-1:0];
        CFG_LEAD_TIME:       cfg.lead_time       <= cfg_data[LeadTimeW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (in_take) begin
      sample_valid <= 1'b1;
    end else if (advance) begin
      sample_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      sample.close_button <= close_button;
      sample.open_button  <= open_button;
      sample.tick         <= tick;
    end
  end

  // edge detect, stop checks and lead wait
  rsrc_step u_step (
    .cfg        (cfg),
    .state      (state),
    .sample     (sample),
    .state_next (state_next),
    .result     (result_next)
  );

  // shutter state commits together with the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign run_relay_first  = result.run_relay_first;
  assign dir_relay_first  = result.dir_relay_first;
  assign run_relay_second = result.run_relay_second;
  assign dir_relay_second = result.dir_relay_second;
  assign motion_phase     = result.motion_phase;

endmodule

// ===== hw/rtl/rsrc_checker.sv =====
// port checker for the roller shutter relay controller, with its bind
module rsrc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       run_relay_first,
  input logic       dir_relay_first,
  input logic       run_relay_second,
  input logic       dir_relay_second,
  input logic [1:0] motion_phase
);
  import rsrc_pkg::*;

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // idle means every relay is off
  a_idle_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && motion_phase == PHASE_IDLE |->
      !run_relay_first && !run_relay_second && !dir_relay_first && !dir_relay_second)
    else $error("relay on while idle");

  // closing never raises a direction relay and keeps at least one motor running
  a_close_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && motion_phase == PHASE_CLOSING |->
      !dir_relay_first && !dir_relay_second && (run_relay_first || run_relay_second))
    else $error("bad relays while closing");

  // lead wait: both directions up, motors off
  a_lead: assert property (@(posedge clk) disable iff (rst)
    out_valid && motion_phase == PHASE_LEAD |->
      dir_relay_first && dir_relay_second && !run_relay_first && !run_relay_second)
    else $error("bad relays in lead wait");

  // opening: each motor runs exactly with its direction up
  a_open_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && motion_phase == PHASE_OPENING |->
      run_relay_first == dir_relay_first && run_relay_second == dir_relay_second)
    else $error("run and direction disagree while opening");

endmodule

bind roller_shutter_relay_controller rsrc_checker u_rsrc_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .run_relay_first  (run_relay_first),
  .dir_relay_first  (dir_relay_first),
  .run_relay_second (run_relay_second),
  .dir_relay_second (dir_relay_second),
  .motion_phase     (motion_phase)
);

// ===== sim/tb_top.sv =====
// self-checking testbench of the two-shutter roller relay controller
module tb_top;
  import rsrc_pkg::*;

  // result of a word passes through the sample register and then the result register
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 64;
  localparam int CYCLE_LIMIT  = 1000000;
  // index with no register behind it, writes there are dropped
  localparam logic [CfgIndexW-1:0] CFG_UNMAPPED = 2'd3;

  // idling schedule of the two channels
  typedef enum int {
    PACE_SLOW_SINK,
    PACE_SLOW_SOURCE,
    PACE_FULL
  } pace_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_we    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;

  logic in_valid     = 1'b0;
  logic in_stall;
  logic close_button = 1'b0;
  logic open_button  = 1'b0;
  logic tick         = 1'b0;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       run_relay_first;
  logic       dir_relay_first;
  logic       run_relay_second;
  logic       dir_relay_second;
  logic [1:0] motion_phase;

  roller_shutter_relay_controller DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .close_button     (close_button),
    .open_button      (open_button),
    .tick             (tick),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .run_relay_first  (run_relay_first),
    .dir_relay_first  (dir_relay_first),
    .run_relay_second (run_relay_second),
    .dir_relay_second (dir_relay_second),
    .motion_phase     (motion_phase)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // samples waiting to be offered, relay words waiting to come out
  rsrc_sample_t sample_queue[$];
  rsrc_result_t relay_queue[$];
  rsrc_sample_t offered;
  int           pushed = 0;
  int           mismatch_count = 0;
  int           cycle_count = 0;
  pace_t        pace = PACE_SLOW_SINK;
  int           hold_seq = 0;

  // shadow of the configuration, updated as each write is issued
  logic [RunTimeW-1:0]  cfg_rt_first  = RunTimeReset;
  logic [RunTimeW-1:0]  cfg_rt_second = RunTimeReset;
  logic [LeadTimeW-1:0] cfg_lead      = LeadTimeReset;

  // shadow of the shutter state
  logic                last_close = 1'b0;
  logic                last_open  = 1'b0;
  logic [1:0]          closing    = 2'b00;
  logic [1:0]          opening    = 2'b00;
  logic                lead_wait  = 1'b0;
  logic [ElapsedW-1:0] elapsed    = '0;

  // a press stops both shutters, else each stops when its run time is used up
  function automatic logic [1:0] trim_running(logic [1:0] bits, logic pressed);
    if (pressed) return 2'b00;
    if (elapsed >= cfg_rt_first) bits[0] = 1'b0;
    if (elapsed >= cfg_rt_second) bits[1] = 1'b0;
    return bits;
  endfunction

  // advances the shadow state by one sample and returns the relay word it shows
  function automatic rsrc_result_t predict_relays(rsrc_sample_t s);
    logic         close_edge;
    logic         open_edge;
    logic [1:0]   active;
    rsrc_result_t r;
    // tick is counted before any comparison in the same sample
    if (s.tick && elapsed != ElapsedMax) elapsed = elapsed + 1'b1;
    // during the lead wait the buttons are not looked at and the levels hold
    if (!lead_wait) begin
      close_edge = s.close_button && !last_close;
      open_edge  = s.open_button && !last_open;
      last_close = s.close_button;
      last_open  = s.open_button;
      if (closing != 2'b00) begin
        closing = trim_running(closing, close_edge || open_edge);
      end else if (opening != 2'b00) begin
        opening = trim_running(opening, close_edge || open_edge);
      end else if (open_edge) begin
        // open wins over a close pressed in the same sample
        lead_wait = 1'b1;
        elapsed   = '0;
      end else if (close_edge) begin
        closing = 2'b11;
        elapsed = '0;
      end
    end
    // the wait may end in the very sample that started it
    if (lead_wait && elapsed >= ElapsedW'(cfg_lead)) begin
      lead_wait = 1'b0;
      opening   = 2'b11;
      elapsed   = '0;
    end
    active = closing | opening;
    r.run_relay_first  = active[0];
    r.dir_relay_first  = lead_wait | opening[0];
    r.run_relay_second = active[1];
    r.dir_relay_second = lead_wait | opening[1];
    if (lead_wait) r.motion_phase = PHASE_LEAD;
    else if (closing != 2'b00) r.motion_phase = PHASE_CLOSING;
    else if (opening != 2'b00) r.motion_phase = PHASE_OPENING;
    else r.motion_phase = PHASE_IDLE;
    return r;
  endfunction

  function automatic int send_idle_pct();
    case (pace)
      PACE_SLOW_SINK:   return 34;
      PACE_SLOW_SOURCE: return 74;
      default:          return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case (pace)
      PACE_SLOW_SINK:   return 74;
      PACE_SLOW_SOURCE: return 34;
      default:          return 0;
    endcase
  endfunction

  // driver: a word is taken when valid is high and stall low at an edge,
  // a new one is offered only once the slot is free
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) relay_queue.push_back(predict_relays(offered));
      if (!in_valid || !in_stall) begin
        if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          offered = sample_queue.pop_front();
          close_button <= offered.close_button;
          open_button  <= offered.open_button;
          tick         <= offered.tick;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each taken relay word against the oldest prediction
  int           hold_seen = 0;
  int           hold_left = 0;
  rsrc_result_t want;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (relay_queue.size() == 0) begin
          $error("relay word with no prediction waiting");
          mismatch_count++;
        end else begin
          want = relay_queue.pop_front();
          if (run_relay_first !== want.run_relay_first) begin
            $error("run_relay_first expected %0d got %0d", want.run_relay_first,
                   run_relay_first);
            mismatch_count++;
          end
          if (dir_relay_first !== want.dir_relay_first) begin
            $error("dir_relay_first expected %0d got %0d", want.dir_relay_first,
                   dir_relay_first);
            mismatch_count++;
          end
          if (run_relay_second !== want.run_relay_second) begin
            $error("run_relay_second expected %0d got %0d", want.run_relay_second,
                   run_relay_second);
            mismatch_count++;
          end
          if (dir_relay_second !== want.dir_relay_second) begin
            $error("dir_relay_second expected %0d got %0d", want.dir_relay_second,
                   dir_relay_second);
            mismatch_count++;
          end
          if (motion_phase !== want.motion_phase) begin
            $error("motion_phase expected %0d got %0d", want.motion_phase, motion_phase);
            mismatch_count++;
          end
        end
      end
      // long hold-off on request, so the block backs up into its input
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void push_sample(logic cb, logic ob, logic tk);
    rsrc_sample_t s;
    s.close_button = cb;
    s.open_button  = ob;
    s.tick         = tk;
    sample_queue.push_back(s);
    pushed++;
  endfunction

  function automatic logic tick_roll();
    return $urandom_range(0, 99) < 75;
  endfunction

  // mostly clean presses with a quiet gap after, the rest button noise
  task automatic push_random(int count);
    int   target;
    int   pick;
    logic cb;
    logic ob;
    target = pushed + count;
    while (pushed < target) begin
      if ($urandom_range(0, 99) < 70) begin
        pick = $urandom_range(0, 9);
        cb = (pick < 5) || (pick == 9);
        ob = (pick >= 5);
        repeat ($urandom_range(1, 3)) push_sample(cb, ob, tick_roll());
        repeat ($urandom_range(0, 30)) push_sample(1'b0, 1'b0, tick_roll());
      end else begin
        repeat ($urandom_range(1, 4))
          push_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_RUN_TIME_FIRST:  cfg_rt_first  = data;
      CFG_RUN_TIME_SECOND: cfg_rt_second = data;
      CFG_LEAD_TIME:       cfg_lead      = data[LeadTimeW-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_times(logic [CfgDataW-1:0] rt1, logic [CfgDataW-1:0] rt2,
                           logic [CfgDataW-1:0] lead);
    write_reg(CFG_RUN_TIME_FIRST, rt1);
    write_reg(CFG_RUN_TIME_SECOND, rt2);
    write_reg(CFG_LEAD_TIME, lead);
  endtask

  // block is idle once every offered word is out and the pipeline has emptied
  task automatic wait_drained();
    while (sample_queue.size() != 0 || in_valid || relay_queue.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset values: lead wait of 100 ticks, then an open run and a close run, each stopped by a press
    pace = PACE_SLOW_SINK;
    push_sample(1'b0, 1'b1, 1'b1);
    repeat (100) push_sample(1'b0, 1'b0, 1'b1);
    push_sample(1'b1, 1'b0, 1'b0);
    push_sample(1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 1'b0, 1'b0);
    repeat (20) push_sample(1'b0, 1'b0, 1'b1);
    push_sample(1'b0, 1'b1, 1'b0);
    push_sample(1'b0, 1'b0, 1'b0);
    wait_drained();

    // directed cases, lead data with junk above bit 9, a write to no register
    set_times(16'd2, 16'd4, {6'h2A, 10'd2});
    write_reg(CFG_UNMAPPED, 16'h0000);
    push_sample(1'b0, 1'b0, 1'b1);
    push_sample(1'b1, 1'b0, 1'b0);  // close press starts both motors
    push_sample(1'b1, 1'b0, 1'b1);  // held level, no edge
    push_sample(1'b0, 1'b0, 1'b1);  // first shutter runs out
    push_sample(1'b0, 1'b0, 1'b1);
    push_sample(1'b0, 1'b0, 1'b1);  // second runs out
    push_sample(1'b0, 1'b1, 1'b1);  // open press, lead wait
    push_sample(1'b1, 1'b0, 1'b1);  // ignored during the wait
    push_sample(1'b1, 1'b1, 1'b1);  // wait ends, levels still held
    push_sample(1'b1, 1'b0, 1'b0);  // close edge against held level stops all
    push_sample(1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 1'b1, 1'b0);  // both at once, open wins
    push_sample(1'b0, 1'b0, 1'b1);
    push_sample(1'b0, 1'b0, 1'b1);
    push_sample(1'b0, 1'b0, 1'b1);
    push_sample(1'b0, 1'b0, 1'b1);  // first stops, its direction drops
    push_sample(1'b0, 1'b0, 1'b1);
    push_sample(1'b0, 1'b0, 1'b1);
    push_sample(1'b1, 1'b0, 1'b0);
    push_sample(1'b0, 1'b1, 1'b0);  // open press while closing stops
    push_sample(1'b0, 1'b0, 1'b0);
    wait_drained();

    // zero lead and run times
    write_reg(CFG_UNMAPPED, 16'hFFFF);
    set_times(16'd0, 16'd0, 16'd0);
    push_random(300);
    wait_drained();

    pace = PACE_SLOW_SOURCE;
    set_times(16'd3, 16'd7, 16'd2);
    push_random(350);
    wait_drained();

    set_times(16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
              16'($urandom_range(0, 6)));
    push_random(350);
    wait_drained();

    set_times(16'hFFFF, 16'd5, 16'd1);
    push_random(300);
    wait_drained();

    // no idling, with one long hold-off on the result side
    pace = PACE_FULL;
    set_times(16'd9, 16'd20, 16'd4);
    push_random(400);
    hold_seq++;
    wait_drained();

    // widest run time, lead data with every bit above the field set
    set_times(16'hFFFF, 16'd3, 16'hFC05);
    push_sample(1'b0, 1'b1, 1'b1);
    repeat (12) push_sample(1'b0, 1'b0, 1'b1);
    push_sample(1'b1, 1'b0, 1'b0);
    push_sample(1'b0, 1'b0, 1'b1);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
